@@ rtl/lrsh_pkg.sv @@
package lrsh_pkg;

    localparam int DIST_W  = 24;
    localparam int TIME_W  = 48;
    localparam int FRAME_W = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    typedef logic [1:0] tier_t;

    localparam tier_t TIER_FAST   = 2'd0;
    localparam tier_t TIER_MID    = 2'd1;
    localparam tier_t TIER_SLOW   = 2'd2;
    localparam tier_t TIER_FROZEN = 2'd3;

    localparam logic CMD_SCHEDULE = 1'b0;
    localparam logic CMD_FORGET   = 1'b1;

    localparam logic [1:0] GRACE_FRAMES = 2'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NEAR_BAND   = 3'd0,
        CFG_MID_BAND    = 3'd1,
        CFG_FROZEN_BAND = 3'd2,
        CFG_HYSTERESIS  = 3'd3,
        CFG_PERIOD_FAST = 3'd4,
        CFG_PERIOD_MID  = 3'd5,
        CFG_PERIOD_SLOW = 3'd6
    } cfg_reg_t;

    localparam logic [CFG_DATA_W-1:0] NEAR_BAND_RESET   = 24'd10000;
    localparam logic [CFG_DATA_W-1:0] MID_BAND_RESET    = 24'd30000;
    localparam logic [CFG_DATA_W-1:0] FROZEN_BAND_RESET = 24'd80000;
    localparam logic [CFG_DATA_W-1:0] HYSTERESIS_RESET  = 24'd1000;
    localparam logic [CFG_DATA_W-1:0] PERIOD_FAST_RESET = 24'd16667;
    localparam logic [CFG_DATA_W-1:0] PERIOD_MID_RESET  = 24'd33333;
    localparam logic [CFG_DATA_W-1:0] PERIOD_SLOW_RESET = 24'd66667;

    typedef struct packed {
        logic               cmd;
        logic [5:0]         slot;
        logic [FRAME_W-1:0] frame_number;
        logic               is_visible;
        logic               distance_known;
        logic [DIST_W-1:0]  distance_mm;
        logic [TIME_W-1:0]  now_us;
    } sched_req_t;

    // Bit order matches the packed stored decision: newly, resample, eval, tier.
    typedef struct packed {
        logic  newly_shown;
        logic  resample_time;
        logic  eval_due;
        tier_t rate_tier;
    } sched_rsp_t;

    localparam sched_rsp_t RSP_IDLE = '{
        newly_shown:   1'b0,
        resample_time: 1'b0,
        eval_due:      1'b0,
        rate_tier:     TIER_FROZEN
    };

    typedef struct packed {
        logic               used;
        logic [FRAME_W-1:0] last_frame;
        logic               shown;
        logic [1:0]         grace_left;
        tier_t              current_tier;
        logic [TIME_W-1:0]  due_time;
        logic               seed_pending;
        tier_t              seed_tier;
        sched_rsp_t         stored_result;
    } slot_entry_t;

    // Band select with hysteresis widened around the previous tier.
    function automatic tier_t pick_tier(
        input tier_t             prev,
        input logic              known,
        input logic [DIST_W-1:0] d,
        input logic [DIST_W-1:0] near_b,
        input logic [DIST_W-1:0] mid_b,
        input logic [DIST_W-1:0] frozen_b,
        input logic [DIST_W-1:0] hyst
    );
        logic [DIST_W:0] d_h;
        logic [DIST_W:0] near_h;
        logic [DIST_W:0] mid_h;
        logic [DIST_W:0] frozen_h;
        logic [DIST_W:0] d_x;
        logic [DIST_W:0] near_x;
        logic [DIST_W:0] mid_x;
        logic [DIST_W:0] frozen_x;
        tier_t           t;
        d_x      = {1'b0, d};
        near_x   = {1'b0, near_b};
        mid_x    = {1'b0, mid_b};
        frozen_x = {1'b0, frozen_b};
        d_h      = d_x + {1'b0, hyst};
        near_h   = near_x + {1'b0, hyst};
        mid_h    = mid_x + {1'b0, hyst};
        frozen_h = frozen_x + {1'b0, hyst};
        t = TIER_FROZEN;
        if (known) begin
            case (prev)
                TIER_FAST: begin
                    if (d_x <= near_h)        t = TIER_FAST;
                    else if (d_x <= mid_x)    t = TIER_MID;
                    else if (d_x <= frozen_x) t = TIER_SLOW;
                    else                      t = TIER_FROZEN;
                end
                TIER_MID: begin
                    if (d_h < near_x)         t = TIER_FAST;
                    else if (d_x <= mid_h)    t = TIER_MID;
                    else if (d_x <= frozen_x) t = TIER_SLOW;
                    else                      t = TIER_FROZEN;
                end
                TIER_SLOW: begin
                    if (d_h < near_x)         t = TIER_FAST;
                    else if (d_h < mid_x)     t = TIER_MID;
                    else if (d_x <= frozen_h) t = TIER_SLOW;
                    else                      t = TIER_FROZEN;
                end
                default: begin
                    if (d_h >= frozen_x)      t = TIER_FROZEN;
                    else if (d_x < near_x)    t = TIER_FAST;
                    else if (d_x < mid_x)     t = TIER_MID;
                    else                      t = TIER_SLOW;
                end
            endcase
        end
        return t;
    endfunction

endpackage

@@ rtl/lrsh_in_if.sv @@
interface lrsh_in_if;
    import lrsh_pkg::*;

    logic       valid;
    logic       ready;
    sched_req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/lrsh_out_if.sv @@
interface lrsh_out_if;
    import lrsh_pkg::*;

    logic       valid;
    logic       ready;
    sched_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/lrsh_ram.sv @@
module lrsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ rtl/lod_rate_scheduler_hysteresis_core.sv @@
// Per-slot update-rate scheduler with distance hysteresis.
// Channels: req (sink) takes one schedule or forget beat; rsp (source) gives one
// beat per schedule request and none per forget. Both use valid/ready; a beat
// moves on a rising edge with valid and ready high.
// Configuration: cfg_we writes cfg_data into the register at cfg_index on the
// same edge; write only while no request is in flight.
// Path: an accepted request beat is registered into the compute stage together
// with its RAM read, and the computed result then loads the response register,
// from which its response beat moves.
// Throughput: one beat per cycle while no response stalls; a request reads its
// entry in the slot table RAM and, except for a repeat frame or a bad slot,
// writes it back; a one-entry bypass covers a back-to-back same-slot request.
// Reset: configuration returns to its defaults and the slot table is swept,
// one entry per cycle, all SLOTS entries; req.ready stays low during the sweep.
// Stall: when rsp.ready is low the response register holds its beat; one more
// schedule request can sit in the compute stage, then req.ready drops until the
// response is taken.
module lod_rate_scheduler_hysteresis_core #(
    parameter int SLOTS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lrsh_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lrsh_pkg::CFG_DATA_W-1:0]     cfg_data,
    lrsh_in_if.sink                             req,
    lrsh_out_if.source                          rsp
);
    import lrsh_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int EW = $bits(slot_entry_t);
    localparam logic [31:0] SLOT_LIMIT = 32'(SLOTS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);

    // Configuration registers
    logic [DIST_W-1:0] near_band_reg, mid_band_reg, frozen_band_reg, hysteresis_reg;
    logic [DIST_W-1:0] period_fast_reg, period_mid_reg, period_slow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_band_reg   <= NEAR_BAND_RESET;
            mid_band_reg    <= MID_BAND_RESET;
            frozen_band_reg <= FROZEN_BAND_RESET;
            hysteresis_reg  <= HYSTERESIS_RESET;
            period_fast_reg <= PERIOD_FAST_RESET;
            period_mid_reg  <= PERIOD_MID_RESET;
            period_slow_reg <= PERIOD_SLOW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_NEAR_BAND:   near_band_reg   <= cfg_data;
                CFG_MID_BAND:    mid_band_reg    <= cfg_data;
                CFG_FROZEN_BAND: frozen_band_reg <= cfg_data;
                CFG_HYSTERESIS:  hysteresis_reg  <= cfg_data;
                CFG_PERIOD_FAST: period_fast_reg <= cfg_data;
                CFG_PERIOD_MID:  period_mid_reg  <= cfg_data;
                CFG_PERIOD_SLOW: period_slow_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline control
    logic            clearing_reg;
    logic [AW-1:0]   clear_addr_reg;
    logic            s1_valid_reg;
    sched_req_t      s1_req_reg;
    logic            rsp_valid_reg;
    sched_rsp_t      rsp_data_reg;
    logic            fwd_valid_reg;
    logic [AW-1:0]   fwd_addr_reg;
    slot_entry_t     fwd_data_reg;

    logic            req_fire;
    logic            s1_advance;
    logic            s1_has_rsp;
    logic [AW-1:0]   s1_addr;
    logic            s1_slot_ok;

    logic            item_we;
    slot_entry_t     item_wdata;
    sched_rsp_t      s1_rsp;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [EW-1:0]   ram_wdata;
    logic [EW-1:0]   ram_rdata;

    assign req_fire   = req.valid && req.ready;
    assign s1_has_rsp = s1_req_reg.cmd == CMD_SCHEDULE;
    assign s1_advance = s1_valid_reg && (!s1_has_rsp || !rsp_valid_reg || rsp.ready);
    assign req.ready  = !clearing_reg && (!s1_valid_reg || s1_advance);
    assign s1_addr    = AW'(s1_req_reg.slot);
    assign s1_slot_ok = (s1_req_reg.slot != '0) && (32'(s1_req_reg.slot) < SLOT_LIMIT);

    assign ram_we    = clearing_reg || (item_we && s1_advance);
    assign ram_waddr = clearing_reg ? clear_addr_reg : s1_addr;
    assign ram_wdata = clearing_reg ? EW'(0) : EW'(item_wdata);

    lrsh_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (req_fire),
        .raddr (AW'(req.data.slot)),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
            s1_valid_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clear_addr_reg <= clear_addr_reg + AW'(1);
                if (clear_addr_reg == LAST_ADDR)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (req_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance && s1_has_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (item_we && s1_advance)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_req_reg <= req.data;
        end
        if (s1_advance && s1_has_rsp)
        begin
            rsp_data_reg <= s1_rsp;
        end
        if (item_we && s1_advance)
        begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= item_wdata;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // Compute stage
    slot_entry_t       ent;
    slot_entry_t       base;
    slot_entry_t       upd;
    logic              repeat_hit;
    logic              became;
    logic [1:0]        grace0;
    tier_t             cur0;
    logic [TIME_W-1:0] due0;
    tier_t             pick_cur;
    tier_t             pick_seed;
    tier_t             sel;
    logic              eval_now;
    logic              resample;
    logic [TIME_W-1:0] step;
    logic [TIME_W:0]   carried_sum;
    logic [TIME_W:0]   snap_sum;
    logic [TIME_W-1:0] carried;
    logic [TIME_W-1:0] snapped;
    sched_rsp_t        vis_rsp;

    assign ent = (fwd_valid_reg && fwd_addr_reg == s1_addr) ? fwd_data_reg
                                                             : slot_entry_t'(ram_rdata);

    assign pick_cur  = pick_tier(cur0, s1_req_reg.distance_known, s1_req_reg.distance_mm,
                                 near_band_reg, mid_band_reg, frozen_band_reg,
                                 hysteresis_reg);
    assign pick_seed = pick_tier(TIER_FROZEN, s1_req_reg.distance_known,
                                 s1_req_reg.distance_mm, near_band_reg, mid_band_reg,
                                 frozen_band_reg, hysteresis_reg);

    always_comb
    begin
        base = ent;
        if (!ent.used)
        begin
            base.shown        = 1'b0;
            base.grace_left   = '0;
            base.current_tier = TIER_FROZEN;
            base.due_time     = '0;
            base.seed_pending = 1'b0;
            base.seed_tier    = TIER_FROZEN;
        end
        repeat_hit = ent.used && (ent.last_frame == s1_req_reg.frame_number);

        became = !base.shown;
        grace0 = became ? GRACE_FRAMES : base.grace_left;
        cur0   = became ? TIER_FAST : base.current_tier;
        due0   = became ? s1_req_reg.now_us : base.due_time;

        sel = TIER_FAST;
        if (grace0 == '0)
        begin
            sel = base.seed_pending ? base.seed_tier : pick_cur;
        end
        resample = became || (sel < cur0);
        eval_now = (sel != TIER_FROZEN) && (s1_req_reg.now_us >= due0);

        case (sel)
            TIER_FAST: step = TIME_W'(period_fast_reg);
            TIER_MID:  step = TIME_W'(period_mid_reg);
            default:   step = TIME_W'(period_slow_reg);
        endcase
        // Saturate deadline sums at the top of the time range
        carried_sum = {1'b0, due0} + {1'b0, step};
        snap_sum    = {1'b0, s1_req_reg.now_us} + {1'b0, step};
        carried     = carried_sum[TIME_W] ? '1 : carried_sum[TIME_W-1:0];
        snapped     = snap_sum[TIME_W] ? '1 : snap_sum[TIME_W-1:0];

        vis_rsp.rate_tier     = sel;
        vis_rsp.eval_due      = eval_now;
        vis_rsp.resample_time = resample;
        vis_rsp.newly_shown   = grace0 != '0;

        upd            = base;
        upd.used       = 1'b1;
        upd.last_frame = s1_req_reg.frame_number;
        if (!s1_req_reg.is_visible)
        begin
            upd.shown         = 1'b0;
            upd.grace_left    = '0;
            upd.current_tier  = TIER_FROZEN;
            upd.due_time      = s1_req_reg.now_us;
            upd.stored_result = RSP_IDLE;
        end
        else
        begin
            upd.shown        = 1'b1;
            upd.current_tier = sel;
            upd.due_time     = due0;
            if (eval_now)
            begin
                upd.due_time = (carried < s1_req_reg.now_us) ? snapped : carried;
            end
            upd.grace_left   = grace0;
            if (grace0 == '0)
            begin
                upd.seed_pending = 1'b0;
            end
            else
            begin
                upd.grace_left = grace0 - 2'd1;
                // Last grace frame: seed the next tier from the bands as seen from frozen
                if (grace0 == 2'd1)
                begin
                    upd.seed_tier    = pick_seed;
                    upd.seed_pending = 1'b1;
                end
            end
            upd.stored_result = vis_rsp;
        end

        item_we    = 1'b0;
        item_wdata = upd;
        s1_rsp     = RSP_IDLE;
        if (s1_req_reg.cmd == CMD_FORGET)
        begin
            item_we         = s1_slot_ok;
            item_wdata      = ent;
            item_wdata.used = 1'b0;
        end
        else if (!s1_slot_ok)
        begin
            s1_rsp = RSP_IDLE;
        end
        else if (repeat_hit)
        begin
            s1_rsp = ent.stored_result;
        end
        else
        begin
            item_we = 1'b1;
            s1_rsp  = upd.stored_result;
        end
    end

    // Assertions
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !req.ready)
        else $error("request accepted during table sweep");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_slot_ok) |-> !item_we)
        else $error("table write for an invalid slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.rate_tier == TIER_FROZEN) |-> !rsp.data.eval_due)
        else $error("evaluation flagged on frozen tier");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.newly_shown) |-> (rsp.data.rate_tier == TIER_FAST))
        else $error("grace frame not at the fast tier");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && item_we) |=> (fwd_valid_reg && fwd_addr_reg == $past(s1_addr)))
        else $error("bypass entry not captured after table write");
endmodule
